[sv/bwb_pkg.sv]
// bwb_pkg: shared types, widths and codes for the biome weight blend block.
// No dependencies; every other file of the block imports it.
package bwb_pkg;

  localparam int GRID_DIM    = 128;
  localparam int BIOME_COUNT = 8;

  localparam int IDX_W   = $clog2(GRID_DIM);
  localparam int DIM_W   = IDX_W + 1;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int BSEL_W  = $clog2(BIOME_COUNT);
  localparam int MEM_W   = BIOME_COUNT * 8;
  localparam int WGT_W   = 17;
  localparam int VAL_W   = 24;
  localparam int SUM_W   = VAL_W + BSEL_W;
  localparam int QW      = 17;
  localparam int NUM_W   = VAL_W + 17;
  localparam int QDIV_W  = 31;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_WORLD = 2'd1;
  localparam logic [1:0] CMD_NODE  = 2'd2;

  localparam logic [1:0] CFG_COLS    = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;
  localparam logic [1:0] CFG_SPACING = 2'd2;

  localparam logic [1:0] TK_WRITE = 2'd0;
  localparam logic [1:0] TK_QUERY = 2'd1;
  localparam logic [1:0] TK_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [23:0] world_x;
    logic signed [23:0] world_z;
    logic signed [15:0] node_x;
    logic signed [15:0] node_z;
    logic [2:0]         biome_select;
    logic [7:0]         coverage_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  biome_index;
    logic [16:0] weight;
    logic [2:0]  dominant_biome;
    logic        last;
  } out_item_t;

  // One unit of work for the back end. Corner order: x0z0, x1z0, x0z1, x1z1.
  typedef struct packed {
    logic [1:0]                  kind;
    logic [2:0]                  biome;
    logic [7:0]                  data;
    logic [IDX_W-1:0]            x0;
    logic [IDX_W-1:0]            x1;
    logic [IDX_W-1:0]            z0;
    logic [IDX_W-1:0]            z1;
    logic [3:0][WGT_W-1:0]       wt;
  } task_t;

endpackage

[sv/biome_weight_bilinear_blend.sv]
// biome_weight_bilinear_blend: top level, front end, task queue and back end.
// Depends on bwb_pkg, bwb_front, bwb_queue and bwb_back.
//
//  channel | ports                        | moves
//  --------+------------------------------+-------------------------------
//  cfg     | cfg_valid/ready/index/data   | register write request
//  in      | in_valid/ready/data          | command request (in_item_t)
//  out     | out_valid/ready/data         | one biome result (out_item_t)
//
// World query: the front classifies, runs a 31-step divide on both axes, forms the
// corner weights and pushes; the back then blends the four corners over all biomes
// and runs the bit-serial normalizing divide per biome. Node queries skip the front divide.
// After reset the back clears the store, one node word per cycle, all 16384 words,
// with in_ready low; cfg is always taken. The two-entry queue and the output register
// let front and back stall independently.
module biome_weight_bilinear_blend (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  bwb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bwb_pkg::out_item_t out_data
);
  import bwb_pkg::*;

  // front -> queue
  logic  f_valid, f_ready;
  task_t f_task;
  // queue -> back
  logic  b_valid, b_ready;
  task_t b_task;
  // back is sweeping the store after reset
  logic  clearing;

  bwb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .clearing   (clearing),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_task)
  );

  bwb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_task),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_task)
  );

  bwb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_data  (b_task),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[sv/bwb_front.sv]
// bwb_front: configuration registers, command intake and classification,
// world-to-lattice division and corner weights. Uses bwb_pkg.
module bwb_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  bwb_pkg::in_item_t in_data,
  input  logic             clearing,
  output logic             push_valid,
  input  logic             push_ready,
  output bwb_pkg::task_t   push_data
);
  import bwb_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_CLS  = 3'd1;
  localparam logic [2:0] F_DIV  = 3'd2;
  localparam logic [2:0] F_WGT  = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  typedef struct packed {
    logic [IDX_W-1:0] i0;
    logic [IDX_W-1:0] i1;
    logic [7:0]       t;
  } axis_t;

  function automatic axis_t axis_fn(input logic [QDIV_W-1:0] q, input logic [DIM_W-1:0] n);
    logic [DIM_W-1:0]   nm1;
    logic [DIM_W-1:0]   i0p;
    logic [DIM_W+7:0]   lim;
    logic [QDIV_W-1:0]  qc;
    axis_t              r;
    nm1 = n - 1'b1;
    lim = {nm1, 8'h00};
    qc  = (q > QDIV_W'(lim)) ? QDIV_W'(lim) : q;
    r.i0 = qc[IDX_W+7:8];
    r.t  = qc[7:0];
    i0p  = DIM_W'(r.i0) + 1'b1;
    r.i1 = (i0p < n) ? i0p[IDX_W-1:0] : nm1[IDX_W-1:0];
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] clamp_fn(input logic signed [15:0] v,
                                               input logic [DIM_W-1:0] n);
    logic [DIM_W-1:0] nm1;
    nm1 = n - 1'b1;
    if (v[15]) return '0;
    else if (v[14:0] > 15'(nm1)) return nm1[IDX_W-1:0];
    else return v[IDX_W-1:0];
  endfunction

  logic [2:0]        state_r, state_nxt;
  logic [7:0]        cols_r, rows_r;
  logic [15:0]       spacing_r;
  in_item_t          itm_r;
  task_t             tsk_r;
  logic [QDIV_W-1:0] dx_r, dz_r, qx_r, qz_r;
  logic [15:0]       rx_r, rz_r;
  logic [4:0]        cnt_r;

  logic [DIM_W-1:0]  nx, nz;
  logic [15:0]       sp;
  logic              is_empty, wr_ok;
  logic [16:0]       rx2, rz2, rx_sub, rz_sub;
  logic              xge, zge;
  axis_t             ax, az;
  logic [8:0]        ux, uz;
  logic [17:0]       p00, p10, p01, p11;

  assign nx = (cols_r > GRID_DIM) ? DIM_W'(GRID_DIM) : DIM_W'(cols_r);
  assign nz = (rows_r > GRID_DIM) ? DIM_W'(GRID_DIM) : DIM_W'(rows_r);
  assign sp = (spacing_r == 16'd0) ? 16'd256 : spacing_r;
  assign is_empty = (nx == '0) || (nz == '0);
  assign wr_ok = (int'(itm_r.biome_select) < BIOME_COUNT) &&
                 !itm_r.node_x[15] && (itm_r.node_x[14:0] < 15'(nx)) &&
                 !itm_r.node_z[15] && (itm_r.node_z[14:0] < 15'(nz));

  always_comb begin
    rx2    = {rx_r, dx_r[QDIV_W-1]};
    rz2    = {rz_r, dz_r[QDIV_W-1]};
    xge    = rx2 >= {1'b0, sp};
    zge    = rz2 >= {1'b0, sp};
    rx_sub = rx2 - {1'b0, sp};
    rz_sub = rz2 - {1'b0, sp};
    ax  = axis_fn(qx_r, nx);
    az  = axis_fn(qz_r, nz);
    ux  = 9'd256 - {1'b0, ax.t};
    uz  = 9'd256 - {1'b0, az.t};
    p00 = ux * uz;
    p10 = {1'b0, ax.t} * uz;
    p01 = ux * {1'b0, az.t};
    p11 = {1'b0, ax.t} * {1'b0, az.t};
  end

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state_r == F_IDLE) && !clearing;
  assign push_valid = (state_r == F_PUSH);
  assign push_data  = tsk_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (in_valid && in_ready) state_nxt = F_CLS;
      F_CLS: begin
        case (itm_r.command)
          CMD_WRITE: state_nxt = wr_ok ? F_PUSH : F_IDLE;
          CMD_NODE:  state_nxt = F_PUSH;
          CMD_WORLD: state_nxt = is_empty ? F_PUSH : F_DIV;
          default:   state_nxt = F_IDLE;
        endcase
      end
      F_DIV:  if (cnt_r == 5'(QDIV_W - 1)) state_nxt = F_WGT;
      F_WGT:  state_nxt = F_PUSH;
      F_PUSH: if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      cols_r    <= 8'd0;
      rows_r    <= 8'd0;
      spacing_r <= 16'd256;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_COLS:    cols_r    <= cfg_data[7:0];
          CFG_ROWS:    rows_r    <= cfg_data[7:0];
          CFG_SPACING: spacing_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) itm_r <= in_data;
    case (state_r)
      F_CLS: begin
        tsk_r.biome <= itm_r.biome_select;
        tsk_r.data  <= itm_r.coverage_value;
        tsk_r.wt    <= {17'd0, 17'd0, 17'd0, 17'h10000};
        if (itm_r.command == CMD_WRITE) begin
          tsk_r.kind <= TK_WRITE;
          tsk_r.x0   <= itm_r.node_x[IDX_W-1:0];
          tsk_r.z0   <= itm_r.node_z[IDX_W-1:0];
        end else if (is_empty) begin
          tsk_r.kind <= TK_EMPTY;
        end else begin
          tsk_r.kind <= TK_QUERY;
          tsk_r.x0   <= clamp_fn(itm_r.node_x, nx);
          tsk_r.x1   <= clamp_fn(itm_r.node_x, nx);
          tsk_r.z0   <= clamp_fn(itm_r.node_z, nz);
          tsk_r.z1   <= clamp_fn(itm_r.node_z, nz);
        end
        // non-positive coordinates map to lattice position zero
        dx_r  <= (!itm_r.world_x[23] && itm_r.world_x != 24'sd0) ?
                 {itm_r.world_x[22:0], 8'h00} : '0;
        dz_r  <= (!itm_r.world_z[23] && itm_r.world_z != 24'sd0) ?
                 {itm_r.world_z[22:0], 8'h00} : '0;
        rx_r  <= '0;
        rz_r  <= '0;
        qx_r  <= '0;
        qz_r  <= '0;
        cnt_r <= '0;
      end
      F_DIV: begin
        dx_r  <= {dx_r[QDIV_W-2:0], 1'b0};
        dz_r  <= {dz_r[QDIV_W-2:0], 1'b0};
        rx_r  <= xge ? rx_sub[15:0] : rx2[15:0];
        rz_r  <= zge ? rz_sub[15:0] : rz2[15:0];
        qx_r  <= {qx_r[QDIV_W-2:0], xge};
        qz_r  <= {qz_r[QDIV_W-2:0], zge};
        cnt_r <= cnt_r + 5'd1;
      end
      F_WGT: begin
        tsk_r.x0 <= ax.i0;
        tsk_r.x1 <= ax.i1;
        tsk_r.z0 <= az.i0;
        tsk_r.z1 <= az.i1;
        tsk_r.wt <= {p11[WGT_W-1:0], p01[WGT_W-1:0], p10[WGT_W-1:0], p00[WGT_W-1:0]};
      end
      default: ;
    endcase
  end

endmodule

[sv/bwb_queue.sv]
// bwb_queue: short FIFO of back-end tasks between front and back.
// Uses bwb_pkg for task_t and QUEUE_DEPTH.
module bwb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  bwb_pkg::task_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output bwb_pkg::task_t pop_data
);
  import bwb_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  task_t            ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = ent_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= push_data;
  end

endmodule

[sv/bwb_back.sv]
// bwb_back: coverage store with clearing pass, corner blend, normalizing
// divider and result register. Uses bwb_pkg.
module bwb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  bwb_pkg::task_t    pop_data,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_ready,
  output bwb_pkg::out_item_t out_data
);
  import bwb_pkg::*;

  localparam logic [2:0] B_CLR  = 3'd0;
  localparam logic [2:0] B_IDLE = 3'd1;
  localparam logic [2:0] B_RD   = 3'd2;
  localparam logic [2:0] B_MAC  = 3'd3;
  localparam logic [2:0] B_DLD  = 3'd4;
  localparam logic [2:0] B_DIV  = 3'd5;
  localparam logic [2:0] B_OUT  = 3'd6;

  logic [MEM_W-1:0]  mem [1 << ADDR_W];
  logic [MEM_W-1:0]  mem_q_r;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r;
  task_t             tsk_r;
  logic [1:0]        c_r;
  logic [BSEL_W-1:0] b_r;
  logic [4:0]        it_r;
  logic [VAL_W-1:0]  v_r [BIOME_COUNT];
  logic [SUM_W-1:0]  sum_r;
  logic [VAL_W-1:0]  dval_r;
  logic [BSEL_W-1:0] dom_r;
  logic [SUM_W-1:0]  rem_r;
  logic [QW-1:0]     nlo_r, q_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [ADDR_W-1:0] raddr;
  logic [7:0]        byte_q;
  logic [WGT_W+7:0]  prod;
  logic [VAL_W-1:0]  vnew;
  logic [NUM_W-1:0]  num;
  logic [SUM_W:0]    rem2, rem_sub;
  logic              ge;
  logic              b_last, out_free;

  always_comb begin
    case (c_r)
      2'd0: raddr = {tsk_r.z0, tsk_r.x0};
      2'd1: raddr = {tsk_r.z0, tsk_r.x1};
      2'd2: raddr = {tsk_r.z1, tsk_r.x0};
      default: raddr = {tsk_r.z1, tsk_r.x1};
    endcase
    byte_q  = mem_q_r[{b_r, 3'b000} +: 8];
    prod    = byte_q * tsk_r.wt[c_r];
    vnew    = v_r[b_r] + prod[VAL_W-1:0];
    num     = NUM_W'({v_r[b_r], 16'h0000}) + NUM_W'(sum_r >> 1);
    rem2    = {rem_r, nlo_r[QW-1]};
    ge      = rem2 >= {1'b0, sum_r};
    rem_sub = rem2 - {1'b0, sum_r};
  end

  assign b_last    = (b_r == BSEL_W'(BIOME_COUNT - 1));
  assign out_free  = !out_valid_r || out_ready;
  assign clearing  = (state_r == B_CLR);
  assign pop_ready = (state_r == B_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_CLR:  if (clr_r == '1) state_nxt = B_IDLE;
      B_IDLE: begin
        if (pop_valid) begin
          case (pop_data.kind)
            TK_QUERY: state_nxt = B_RD;
            TK_EMPTY: state_nxt = B_DLD;
            default:  state_nxt = B_IDLE;
          endcase
        end
      end
      B_RD:  state_nxt = B_MAC;
      B_MAC: if (b_last) state_nxt = (c_r == 2'd3) ? B_DLD : B_RD;
      B_DLD: state_nxt = B_DIV;
      B_DIV: if (it_r == 5'(QW - 1)) state_nxt = B_OUT;
      B_OUT: if (out_free) state_nxt = b_last ? B_IDLE : B_DLD;
      default: state_nxt = B_IDLE;
    endcase
  end

  // store: one word per node holds every biome's byte
  always_ff @(posedge clk) begin
    if (state_r == B_CLR) mem[clr_r] <= '0;
    else if (state_r == B_IDLE && pop_valid && pop_data.kind == TK_WRITE)
      mem[{pop_data.z0, pop_data.x0}][{pop_data.biome, 3'b000} +: 8] <= pop_data.data;
    mem_q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLR) clr_r <= clr_r + 1'b1;
      if (state_r == B_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        tsk_r  <= pop_data;
        c_r    <= 2'd0;
        b_r    <= '0;
        sum_r  <= '0;
        dval_r <= '0;
        dom_r  <= '0;
        for (int i = 0; i < BIOME_COUNT; i++) v_r[i] <= '0;
      end
      B_MAC: begin
        v_r[b_r] <= vnew;
        // last corner: value is final, fold into sum and dominant pick
        if (c_r == 2'd3) begin
          sum_r <= sum_r + SUM_W'(vnew);
          if (vnew > dval_r) begin
            dval_r <= vnew;
            dom_r  <= b_r;
          end
        end
        if (b_last) begin
          b_r <= '0;
          c_r <= c_r + 2'd1;
        end else begin
          b_r <= b_r + 1'b1;
        end
      end
      B_DLD: begin
        rem_r <= SUM_W'(num >> QW);
        nlo_r <= num[QW-1:0];
        q_r   <= '0;
        it_r  <= '0;
      end
      B_DIV: begin
        rem_r <= ge ? rem_sub[SUM_W-1:0] : rem2[SUM_W-1:0];
        nlo_r <= {nlo_r[QW-2:0], 1'b0};
        q_r   <= {q_r[QW-2:0], ge};
        it_r  <= it_r + 5'd1;
      end
      B_OUT: begin
        if (out_free) begin
          out_r.biome_index    <= 3'(b_r);
          out_r.weight         <= (sum_r == '0) ? 17'd0 : q_r;
          out_r.dominant_biome <= 3'(dom_r);
          out_r.last           <= b_last;
          b_r                  <= b_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_no_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_CLR |-> !out_valid_r) else $error("result during clearing pass");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.last |-> out_r.biome_index == 3'(BIOME_COUNT - 1))
    else $error("last flag on wrong biome");

  a_end_query: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_OUT && out_free && b_last |=> state_r == B_IDLE && out_valid_r)
    else $error("query did not close after final result");

endmodule

[verif/biome_weight_bilinear_blend_tb.sv]
// biome_weight_bilinear_blend_tb: self-checking testbench for the biome weight blend block.
// Depends on bwb_pkg and biome_weight_bilinear_blend; an in-bench predictor supplies the
// expected per-biome weights and dominant biome for every query request.
`timescale 1ns / 1ps

module biome_weight_bilinear_blend_tb;
  import bwb_pkg::*;

  localparam int  SLICE      = GRID_DIM * GRID_DIM;
  localparam int  SETTLE_CYC = 400;        // > one world query through front and back
  localparam longint CYCLE_LIMIT = 3000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0]  cfg_index = CFG_COLS;
  logic [15:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  biome_weight_bilinear_blend dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the block's state and registers.
  logic [7:0]  cov_shadow [0:BIOME_COUNT*SLICE-1];
  logic [7:0]  grid_cols_q;
  logic [7:0]  grid_rows_q;
  logic [15:0] spacing_q;

  out_item_t expected_weights [$];

  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_left = 0;        // long receiver hold-off, counted below
  int     hold_request = 0;
  int     mismatches = 0;
  int     results_seen = 0;
  int     writes_sent = 0;
  int     queries_sent = 0;
  int     cfg_writes = 0;
  longint cycles = 0;
  logic   in_fire = 1'b0;
  logic   cfg_fire = 1'b0;

  // Handshakes are sampled at the rising edge; the driving side looks at
  // these flags on the following falling edge.
  always @(posedge clk) begin
    in_fire  <= in_valid && in_ready;
    cfg_fire <= cfg_valid && cfg_ready;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_weights.size());
      $display("biome_weight_bilinear_blend_tb: FAIL");
      $finish;
    end
  end

  // Hold-off counter runs in its own process; a new request reloads it.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    <= hold_request;
      hold_request <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n || hold_left > 0 || hold_request > 0)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, results_seen);
    mismatches++;
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_weights.size() == 0) begin
        report_mismatch("unexpected result, biome", out_data.biome_index, -1);
      end else begin
        want = expected_weights.pop_front();
        if (out_data.biome_index !== want.biome_index)
          report_mismatch("biome_index", out_data.biome_index, want.biome_index);
        if (out_data.weight !== want.weight)
          report_mismatch("weight", out_data.weight, want.weight);
        if (out_data.dominant_biome !== want.dominant_biome)
          report_mismatch("dominant_biome", out_data.dominant_biome, want.dominant_biome);
        if (out_data.last !== want.last)
          report_mismatch("last", out_data.last, want.last);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int eff_nodes(input logic [7:0] r);
    return (r > GRID_DIM) ? GRID_DIM : int'(r);
  endfunction

  // World coordinate to lattice corner pair plus 8-bit fraction.
  function automatic void lattice_axis(input longint w, input int nodes,
                                       output int i0, output int i1, output int t);
    longint unsigned sp, q, lim;
    sp = (spacing_q == 0) ? 256 : spacing_q;
    i0 = 0; i1 = 0; t = 0;
    if (nodes > 1) begin
      lim = longint'(nodes - 1) << 8;
      q = (w > 0) ? (longint'(w) << 8) / sp : 0;
      if (q > lim) q = lim;
      i0 = int'(q >> 8);
      t  = int'(q & 255);
      i1 = (i0 + 1 < nodes) ? i0 + 1 : nodes - 1;
    end
  endfunction

  function automatic logic [7:0] cov_at(input int b, input int x, input int z);
    return cov_shadow[b*SLICE + z*GRID_DIM + x];
  endfunction

  function automatic void predict_blend(input in_item_t it);
    longint unsigned v [BIOME_COUNT];
    longint unsigned sum, ux, uz;
    longint ix, iz;
    int nx, nz, cx, cz, x0, x1, tx, z0, z1, tz, dom;
    out_item_t r;
    nx = eff_nodes(grid_cols_q);
    nz = eff_nodes(grid_rows_q);
    ix = $signed(it.node_x);
    iz = $signed(it.node_z);
    foreach (v[b]) v[b] = 0;
    if (it.command == CMD_WRITE) begin
      writes_sent++;
      if (it.biome_select < BIOME_COUNT && ix >= 0 && iz >= 0 && ix < nx && iz < nz)
        cov_shadow[int'(it.biome_select)*SLICE + int'(iz)*GRID_DIM + int'(ix)] =
          it.coverage_value;
      return;
    end
    if (it.command != CMD_WORLD && it.command != CMD_NODE) return;  // unused code
    queries_sent++;
    if (nx != 0 && nz != 0) begin
      if (it.command == CMD_NODE) begin
        cx = (ix < 0) ? 0 : ((ix > nx - 1) ? nx - 1 : int'(ix));
        cz = (iz < 0) ? 0 : ((iz > nz - 1) ? nz - 1 : int'(iz));
        for (int b = 0; b < BIOME_COUNT; b++) v[b] = cov_at(b, cx, cz);
      end else begin
        lattice_axis(longint'($signed(it.world_x)), nx, x0, x1, tx);
        lattice_axis(longint'($signed(it.world_z)), nz, z0, z1, tz);
        ux = 256 - tx;
        uz = 256 - tz;
        for (int b = 0; b < BIOME_COUNT; b++)
          v[b] = cov_at(b, x0, z0) * ux * uz + cov_at(b, x1, z0) * tx * uz +
                 cov_at(b, x0, z1) * ux * tz + cov_at(b, x1, z1) * tx * tz;
      end
    end
    sum = 0;
    dom = 0;
    for (int b = 0; b < BIOME_COUNT; b++) begin
      sum += v[b];
      if (v[b] > v[dom]) dom = b;   // strict compare keeps the lower index on ties
    end
    for (int b = 0; b < BIOME_COUNT; b++) begin
      r.biome_index    = 3'(b);
      r.weight         = (sum == 0) ? '0 : 17'(((v[b] << 16) + sum / 2) / sum);
      r.dominant_biome = 3'(dom);
      r.last           = (b == BIOME_COUNT - 1);
      expected_weights.push_back(r);
    end
  endfunction

  // ------------------------------------------------------------ driving side

  // Called on a falling edge. Valid stays high afterwards so back-to-back
  // requests need no gap; end_burst drops it.
  task automatic send_request(input in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(negedge clk); while (!in_fire);
    predict_blend(it);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every expected result is back, then let a trailing write or
  // query finish inside the block.
  task automatic drain();
    end_burst();
    while (expected_weights.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Registers are only written with the block idle.
  task automatic set_grid(input logic [15:0] cols, input logic [15:0] rows,
                          input logic [15:0] spacing);
    logic [15:0] vals [3];
    logic [1:0]  idx [3];
    vals = '{cols, rows, spacing};
    idx  = '{CFG_COLS, CFG_ROWS, CFG_SPACING};
    drain();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(negedge clk); while (!cfg_fire);
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
    grid_cols_q = cols[7:0];
    grid_rows_q = rows[7:0];
    spacing_q   = spacing;
    @(negedge clk);
  endtask

  function automatic in_item_t mk(input logic [1:0] cmd, input int nx, input int nz,
                                  input int wx, input int wz, input int b, input int val);
    in_item_t it;
    it.command        = cmd;
    it.node_x         = 16'(nx);
    it.node_z         = 16'(nz);
    it.world_x        = 24'(wx);
    it.world_z        = 24'(wz);
    it.biome_select   = 3'(b);
    it.coverage_value = 8'(val);
    return it;
  endfunction

  // Random request: all fields noisy, the used ones steered toward the grid.
  function automatic in_item_t random_request();
    in_item_t it;
    int nx, nz, sp, roll, px, pz;
    it = in_item_t'({$urandom, $urandom, $urandom});
    nx = eff_nodes(grid_cols_q);
    nz = eff_nodes(grid_rows_q);
    sp = (spacing_q == 0) ? 256 : spacing_q;
    roll = $urandom_range(99);
    if (roll < 50) begin
      it.command = CMD_WRITE;
      if ($urandom_range(9) != 0) begin
        it.node_x = 16'($urandom_range(nx + 1) - 1);
        it.node_z = 16'($urandom_range(nz + 1) - 1);
      end
      if ($urandom_range(5) == 0) it.coverage_value = $urandom_range(1) ? 8'hFF : 8'h00;
    end else if (roll < 75) begin
      it.command = CMD_WORLD;
      if ($urandom_range(7) != 0) begin
        px = $urandom_range(nx * 256 + 128) - 64;
        pz = $urandom_range(nz * 256 + 128) - 64;
        it.world_x = 24'(longint'(px) * sp / 256);
        it.world_z = 24'(longint'(pz) * sp / 256);
      end
    end else if (roll < 95) begin
      it.command = CMD_NODE;
      if ($urandom_range(5) != 0) begin
        it.node_x = 16'($urandom_range(nx + 3) - 2);
        it.node_z = 16'($urandom_range(nz + 3) - 2);
      end
    end else begin
      it.command = 2'd3;     // unused code, no result
    end
    return it;
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_request(random_request());
    end_burst();
  endtask

  // ------------------------------------------------------------------ tests

  // Reset state: empty grid, so queries give all-zero weights; writes and
  // the unused code are dropped.
  task automatic test_empty_grid();
    send_request(mk(CMD_WRITE, 0, 0, 0, 0, 3, 200));
    send_request(mk(CMD_NODE, 0, 0, 0, 0, 0, 0));
    send_request(mk(CMD_WORLD, 0, 0, 100, 100, 0, 0));
    send_request(mk(2'd3, 0, 0, 0, 0, 0, 0));
    drain();
  endtask

  // Small grid with hand-placed values: out-of-range writes, clamped node
  // queries, world queries at world position zero, ties and a zero-sum node.
  task automatic test_directed_grid();
    set_grid(4, 3, 256);
    send_request(mk(CMD_WRITE, 0, 0, 0, 0, 1, 255));
    send_request(mk(CMD_WRITE, 0, 0, 0, 0, 2, 255));   // tie with biome 1
    send_request(mk(CMD_WRITE, 1, 0, 0, 0, 7, 100));
    send_request(mk(CMD_WRITE, 3, 2, 0, 0, 5, 1));
    send_request(mk(CMD_WRITE, 4, 0, 0, 0, 0, 99));    // x beyond grid
    send_request(mk(CMD_WRITE, -1, 0, 0, 0, 0, 99));
    send_request(mk(CMD_WRITE, 0, 3, 0, 0, 0, 99));    // z beyond grid
    send_request(mk(CMD_WRITE, 32767, -32768, 0, 0, 0, 99));
    send_request(mk(CMD_NODE, 0, 0, 0, 0, 0, 0));
    send_request(mk(CMD_NODE, -32768, -32768, 0, 0, 0, 0));
    send_request(mk(CMD_NODE, 32767, 32767, 0, 0, 0, 0));
    send_request(mk(CMD_NODE, 2, 1, 0, 0, 0, 0));       // zero sum
    send_request(mk(CMD_WORLD, -8388608, -8388608, 0, 0, 0, 0));
    send_request(mk(CMD_WORLD, 8388607, 8388607, 0, 0, 0, 0));
    send_request(mk(CMD_WORLD, 128, 0, 0, 0, 0, 0));    // world coordinates are zero here
    send_request(mk(CMD_WORLD, 383, 511, 0, 0, 0, 0));
    drain();
  endtask

  // Register extremes: one node per axis with zero spacing, oversized grid
  // with the smallest spacing, largest spacing.
  task automatic test_register_extremes();
    set_grid(1, 1, 0);
    send_request(mk(CMD_WORLD, 5000, 5000, 0, 0, 0, 0));
    send_request(mk(CMD_NODE, 9, 9, 0, 0, 0, 0));
    set_grid(16'hFF, 16'hFF80, 1);   // columns above GRID_DIM, rows cut to low byte
    send_request(mk(CMD_WRITE, 127, 127, 0, 0, 4, 77));
    send_request(mk(CMD_WRITE, 126, 127, 0, 0, 6, 33));
    send_request(mk(CMD_WORLD, 8388607, 8388607, 0, 0, 0, 0));
    send_request(mk(CMD_WORLD, 3, 3, 0, 0, 0, 0));
    set_grid(128, 128, 65535);
    send_request(mk(CMD_WORLD, 8388607, 65535, 0, 0, 0, 0));
    drain();
  endtask

  task automatic test_random_phases();
    int phase_idle [4] = '{0, 63, 0, 36};
    int phase_stall [4] = '{0, 0, 63, 36};
    int spacings [4] = '{256, 128, 300, 1000};
    for (int p = 0; p < 4; p++) begin
      set_grid(16'($urandom_range(2, 8)), 16'($urandom_range(2, 8)),
               16'(($urandom_range(3) == 3) ? $urandom_range(1, 65535) : spacings[p]));
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      run_random(70);
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain();
  endtask

  // Receiver holds off while queries keep coming, so the queue and output
  // register fill and in_ready drops.
  task automatic test_output_backpressure();
    in_item_t it;
    set_grid(6, 5, 200);
    hold_request = 3000;
    for (int i = 0; i < 12; i++) begin
      it = random_request();
      it.command = (i % 2) ? CMD_WORLD : CMD_NODE;
      send_request(it);
    end
    drain();
  endtask

  initial begin
    foreach (cov_shadow[i]) cov_shadow[i] = '0;
    grid_cols_q = '0;
    grid_rows_q = '0;
    spacing_q   = 16'd256;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_grid();
    test_directed_grid();
    test_register_extremes();
    test_random_phases();
    test_output_backpressure();

    $display("covered %0d writes, %0d queries, %0d config writes; %0d results checked",
             writes_sent, queries_sent, cfg_writes, results_seen);
    $display("idle/stall phases, long output hold-off, register extremes, empty grid");
    if (mismatches == 0 && expected_weights.size() == 0) begin
      $display("biome_weight_bilinear_blend_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_weights.size());
      $display("biome_weight_bilinear_blend_tb: FAIL");
    end
    $finish;
  end

endmodule

[biome_weight_bilinear_blend.f]
sv/bwb_pkg.sv
sv/bwb_front.sv
sv/bwb_queue.sv
sv/bwb_back.sv
sv/biome_weight_bilinear_blend.sv
verif/biome_weight_bilinear_blend_tb.sv
